@@ rtl/core/msx_hdr_pkg.sv @@
// Types and constants shared by the system-exclusive header parser.
// No dependencies.
package msx_hdr_pkg;

  // framing and class bytes
  localparam logic [7:0] SX_START = 8'hF0;
  localparam logic [7:0] SX_END   = 8'hF7;
  localparam logic [7:0] SX_NONRT = 8'h7E;
  localparam logic [7:0] SX_RT    = 8'h7F;
  localparam logic [7:0] SX_EXT   = 8'h00;

  // header layouts, by class byte
  typedef enum logic [1:0] {
    CLS_ONE   = 2'd0,
    CLS_NONRT = 2'd1,
    CLS_RT    = 2'd2,
    CLS_EXT   = 2'd3
  } cls_e;

  // summary status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_FRAME = 2'd1,
    ST_SHORT_HDR = 2'd2
  } status_e;

  // byte positions of interest
  localparam logic [2:0] POS_FIRST = 3'd0;
  localparam logic [2:0] POS_CLASS = 3'd1;
  localparam logic [2:0] POS_HDR2  = 3'd2;
  localparam logic [2:0] POS_HDR3  = 3'd3;
  localparam logic [2:0] POS_HDR4  = 3'd4;
  localparam logic [2:0] POS_UNIV_PAY = 3'd5;
  localparam logic [2:0] POS_MAX   = 3'd7;

  typedef struct packed {
    logic [2:0]  byte_pos;
    logic        start_ok;
    cls_e        msg_class;
    logic [15:0] maker;
    logic [7:0]  device;
    logic [7:0]  sub_one;
    logic [7:0]  sub_two;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '0;

  typedef struct packed {
    logic [7:0]  sub_two;
    logic [7:0]  sub_one;
    logic [7:0]  device;
    logic [15:0] maker;
    logic        univ_rt;
    logic        univ_nonrt;
    status_e     status;
    logic [7:0]  payload;
    logic        is_summary;
  } result_t;

endpackage

@@ rtl/core/msx_hdr_decode.sv @@
// Per-byte next-state and result logic of the header parser.
// Depends on msx_hdr_pkg.
module msx_hdr_decode import msx_hdr_pkg::*; (
  input  parse_state_t state_i,
  input  logic [7:0]   data_byte_i,
  input  logic         last_i,
  output parse_state_t state_o,
  output logic         res_valid_o,
  output result_t      res_o
);

  logic       universal;
  logic [2:0] pay_start;
  logic       hdr_long;

  assign universal = (state_i.msg_class == CLS_NONRT) || (state_i.msg_class == CLS_RT);
  assign hdr_long  = universal || (state_i.msg_class == CLS_EXT);

  always_comb begin
    unique case (state_i.msg_class)
      CLS_NONRT, CLS_RT: pay_start = POS_UNIV_PAY;
      CLS_EXT:           pay_start = POS_HDR4;
      default:           pay_start = POS_HDR2;
    endcase
  end

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (last_i) begin
      // summary; position below two means fewer than three bytes
      res_valid_o      = 1'b1;
      res_o.is_summary = 1'b1;
      if ((state_i.byte_pos < POS_HDR2) || !state_i.start_ok || (data_byte_i != SX_END)) begin
        res_o.status = ST_BAD_FRAME;
      end else if (hdr_long && (state_i.byte_pos < POS_UNIV_PAY)) begin
        res_o.status = ST_SHORT_HDR;
      end else begin
        res_o.status     = ST_OK;
        res_o.univ_nonrt = (state_i.msg_class == CLS_NONRT);
        res_o.univ_rt    = (state_i.msg_class == CLS_RT);
        res_o.maker      = state_i.maker;
        if (universal) begin
          res_o.device  = state_i.device;
          res_o.sub_one = state_i.sub_one;
          res_o.sub_two = state_i.sub_two;
        end
      end
      state_o = STATE_CLEAR;
    end else begin
      if (state_i.byte_pos == POS_FIRST) begin
        state_o.start_ok = (data_byte_i == SX_START);
      end else if (state_i.byte_pos == POS_CLASS) begin
        priority if (data_byte_i == SX_NONRT) state_o.msg_class = CLS_NONRT;
        else if (data_byte_i == SX_RT)        state_o.msg_class = CLS_RT;
        else if (data_byte_i == SX_EXT)       state_o.msg_class = CLS_EXT;
        else                                  state_o.msg_class = CLS_ONE;
        state_o.maker = {8'h00, data_byte_i};
      end else if (universal) begin
        if (state_i.byte_pos == POS_HDR2) state_o.device  = data_byte_i;
        if (state_i.byte_pos == POS_HDR3) state_o.sub_one = data_byte_i;
        if (state_i.byte_pos == POS_HDR4) state_o.sub_two = data_byte_i;
      end else if (state_i.msg_class == CLS_EXT) begin
        if (state_i.byte_pos == POS_HDR2) state_o.maker = {data_byte_i, 8'h00};
        if (state_i.byte_pos == POS_HDR3) state_o.maker = {state_i.maker[15:8], data_byte_i};
      end

      if (state_i.byte_pos != POS_MAX) begin
        state_o.byte_pos = state_i.byte_pos + 3'd1;
      end

      if ((state_i.byte_pos >= POS_HDR2) && state_i.start_ok &&
          (state_i.byte_pos >= pay_start)) begin
        res_valid_o   = 1'b1;
        res_o.payload = data_byte_i;
      end
    end
  end

endmodule

@@ rtl/core/midi_sysex_header_parser_unit.sv @@
// Top level of the system-exclusive header parser: stream ports, message state
// and result register. Depends on msx_hdr_pkg and msx_hdr_decode.
//
// Takes one system-exclusive message byte per item, tlast on the final byte.
// Payload bytes (those after the header, before the final byte) come out one
// per item as they arrive, provided the message opened with 0xF0; the final
// byte yields one summary item with status and header fields, flagged by tuser.
// A summary with bad framing (status 1) means any payload already passed on
// for that message must be dropped by the receiver. An item is taken every
// cycle that tready is high; a result, if any, shows in the next cycle from a
// single result register, the only thing that can hold the input back:
// tready drops only while a result waits and the output side is stalled.
module midi_sysex_header_parser_unit import msx_hdr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [9:8] status, [10] univ_nonrt,
  // [11] univ_rt, [27:12] manufacturer_code, [35:28] target_device,
  // [43:36] first_sub_id, [51:44] second_sub_id, [55:52] zero
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tuser    // is_summary
);

  parse_state_t state_q, state_d;
  result_t      res_q, res_d;
  logic         res_valid;
  logic         out_valid_q, out_valid_d;
  logic         in_accept;

  // accept while the result register is empty or being emptied this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  msx_hdr_decode u_decode (
    .state_i     (state_q),
    .data_byte_i (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res_d)
  );

  always_comb begin
    if (in_accept) begin
      out_valid_d = res_valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        state_q <= state_d;
      end
    end
  end

  // result payload: loaded only with a fresh result
  always_ff @(posedge clk_i) begin
    if (in_accept && res_valid) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.is_summary;
  assign m_axis_tdata  = {4'h0, res_q.sub_two, res_q.sub_one, res_q.device, res_q.maker,
                          res_q.univ_rt, res_q.univ_nonrt, res_q.status, res_q.payload};

endmodule
